// File: src/spit_pkg.sv
// Shared types and codes for the segment pair intersection test.
package spit_pkg;

  typedef enum logic [1:0] {
    KIND_NONPARALLEL = 2'd0,
    KIND_PARALLEL    = 2'd1,
    KIND_COLLINEAR   = 2'd2,
    KIND_POINT       = 2'd3
  } kind_t;

  // Endpoint tests that only need raw coordinates, settled in the first stage.
  typedef struct packed {
    logic u_point;   // segment A collapses to a point
    logic v_point;   // segment B collapses to a point
    logic pts_equal; // start points coincide
    logic a_in_b;    // A start lies in the coordinate span of B
    logic b_in_a;    // B start lies in the coordinate span of A
  } pt_flags_t;

endpackage

// File: src/spit_prep.sv
// Front-end logic: endpoint differences and point/span tests.
module spit_prep import spit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] a_start_x,
  input  logic signed [COORD_BITS-1:0] a_start_y,
  input  logic signed [COORD_BITS-1:0] a_end_x,
  input  logic signed [COORD_BITS-1:0] a_end_y,
  input  logic signed [COORD_BITS-1:0] b_start_x,
  input  logic signed [COORD_BITS-1:0] b_start_y,
  input  logic signed [COORD_BITS-1:0] b_end_x,
  input  logic signed [COORD_BITS-1:0] b_end_y,
  output logic signed [COORD_BITS:0]   ux,
  output logic signed [COORD_BITS:0]   uy,
  output logic signed [COORD_BITS:0]   vx,
  output logic signed [COORD_BITS:0]   vy,
  output logic signed [COORD_BITS:0]   wx,
  output logic signed [COORD_BITS:0]   wy,
  output logic signed [COORD_BITS:0]   ex,
  output logic signed [COORD_BITS:0]   ey,
  output pt_flags_t                    flags
);

  localparam int DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] a_p, a_s0, a_s1;
  logic signed [COORD_BITS-1:0] b_p, b_s0, b_s1;

  assign ux = DW'(a_end_x) - DW'(a_start_x);
  assign uy = DW'(a_end_y) - DW'(a_start_y);
  assign vx = DW'(b_end_x) - DW'(b_start_x);
  assign vy = DW'(b_end_y) - DW'(b_start_y);
  assign wx = DW'(a_start_x) - DW'(b_start_x);
  assign wy = DW'(a_start_y) - DW'(b_start_y);
  // A end relative to B start, used for collinear overlap
  assign ex = DW'(a_end_x) - DW'(b_start_x);
  assign ey = DW'(a_end_y) - DW'(b_start_y);

  // span test runs on x unless the reference segment is vertical
  always_comb begin
    if (b_start_x != b_end_x) begin
      a_p = a_start_x; a_s0 = b_start_x; a_s1 = b_end_x;
    end else begin
      a_p = a_start_y; a_s0 = b_start_y; a_s1 = b_end_y;
    end
    if (a_start_x != a_end_x) begin
      b_p = b_start_x; b_s0 = a_start_x; b_s1 = a_end_x;
    end else begin
      b_p = b_start_y; b_s0 = a_start_y; b_s1 = a_end_y;
    end
  end

  always_comb begin
    flags.u_point   = (a_start_x == a_end_x) && (a_start_y == a_end_y);
    flags.v_point   = (b_start_x == b_end_x) && (b_start_y == b_end_y);
    flags.pts_equal = (a_start_x == b_start_x) && (a_start_y == b_start_y);
    flags.a_in_b    = ((a_s0 <= a_p) && (a_p <= a_s1)) || ((a_s1 <= a_p) && (a_p <= a_s0));
    flags.b_in_a    = ((b_s0 <= b_p) && (b_p <= b_s1)) || ((b_s1 <= b_p) && (b_p <= b_s0));
  end

endmodule

// File: src/segment_pair_intersection_test.sv
// Top level: four-stage pipelined segment pair intersection test.
//
// Usage: present two segments (A start/end, B start/end, signed
// COORD_BITS coordinates) on the in_ channel with in_valid; the item is
// taken when in_valid and in_ready are both high. Each item yields one
// result on the out_ channel: out_touches is 1 when the segments share a
// point, out_case_kind tells which case decided it (nonparallel, parallel
// apart, collinear, degenerate point).
// Throughput: one item per cycle while out_ready is high; stage 1
// forms differences and point tests, stage 2 the six products and
// the collinear overlap, stage 3 the cross products, stage 4 the
// range compares into the output register.
// Each stage holds its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles close up when out_ready is low
// and in_ready drops only once every stage is full.
// Reset (rst_n low, synchronous) empties the pipeline; no item survives.
module segment_pair_intersection_test import spit_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_a_start_x,
  input  logic signed [COORD_BITS-1:0] in_a_start_y,
  input  logic signed [COORD_BITS-1:0] in_a_end_x,
  input  logic signed [COORD_BITS-1:0] in_a_end_y,
  input  logic signed [COORD_BITS-1:0] in_b_start_x,
  input  logic signed [COORD_BITS-1:0] in_b_start_y,
  input  logic signed [COORD_BITS-1:0] in_b_end_x,
  input  logic signed [COORD_BITS-1:0] in_b_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_touches,
  output logic [1:0]                   out_case_kind
);

  localparam int DW = COORD_BITS + 1;      // coordinate differences
  localparam int PW = 2 * COORD_BITS + 2;  // products
  localparam int CW = 2 * COORD_BITS + 3;  // cross products

  // stage enables
  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // ---------------- stage 1: differences and point tests
  logic signed [DW-1:0] ux_nxt, uy_nxt, vx_nxt, vy_nxt, wx_nxt, wy_nxt, ex_nxt, ey_nxt;
  pt_flags_t            fl_nxt;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r, wx_r, wy_r, ex_r, ey_r;
  pt_flags_t            fl1_r;

  spit_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .a_start_x (in_a_start_x),
    .a_start_y (in_a_start_y),
    .a_end_x   (in_a_end_x),
    .a_end_y   (in_a_end_y),
    .b_start_x (in_b_start_x),
    .b_start_y (in_b_start_y),
    .b_end_x   (in_b_end_x),
    .b_end_y   (in_b_end_y),
    .ux        (ux_nxt),
    .uy        (uy_nxt),
    .vx        (vx_nxt),
    .vy        (vy_nxt),
    .wx        (wx_nxt),
    .wy        (wy_nxt),
    .ex        (ex_nxt),
    .ey        (ey_nxt),
    .flags     (fl_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      ux_r  <= ux_nxt;
      uy_r  <= uy_nxt;
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
      wx_r  <= wx_nxt;
      wy_r  <= wy_nxt;
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
      fl1_r <= fl_nxt;
    end
  end

  // ---------------- stage 2: products and collinear overlap
  logic signed [PW-1:0] p_uxvy_r, p_uyvx_r, p_uxwy_r, p_uywx_r, p_vxwy_r, p_vywx_r;
  pt_flags_t            fl2_r;
  logic                 col_hit_nxt, col_hit2_r;
  logic signed [DW-1:0] cd, cn0, cn1;

  // project onto B's direction along x, or y when B is vertical
  always_comb begin
    if (vx_r != '0) begin
      cd = vx_r; cn0 = wx_r; cn1 = ex_r;
    end else begin
      cd = vy_r; cn0 = wy_r; cn1 = ey_r;
    end
    if (cd > 0) begin
      col_hit_nxt = ((cn0 <= cd) || (cn1 <= cd)) && ((cn0 >= 0) || (cn1 >= 0));
    end else begin
      col_hit_nxt = ((cn0 >= cd) || (cn1 >= cd)) && ((cn0 <= 0) || (cn1 <= 0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      p_uxvy_r   <= PW'(ux_r) * PW'(vy_r);
      p_uyvx_r   <= PW'(uy_r) * PW'(vx_r);
      p_uxwy_r   <= PW'(ux_r) * PW'(wy_r);
      p_uywx_r   <= PW'(uy_r) * PW'(wx_r);
      p_vxwy_r   <= PW'(vx_r) * PW'(wy_r);
      p_vywx_r   <= PW'(vy_r) * PW'(wx_r);
      fl2_r      <= fl1_r;
      col_hit2_r <= col_hit_nxt;
    end
  end

  // ---------------- stage 3: cross products
  logic signed [CW-1:0] den_r, nu_r, nv_r;
  pt_flags_t            fl3_r;
  logic                 col_hit3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      den_r      <= CW'(p_uxvy_r) - CW'(p_uyvx_r);
      nu_r       <= CW'(p_uxwy_r) - CW'(p_uywx_r);
      nv_r       <= CW'(p_vxwy_r) - CW'(p_vywx_r);
      fl3_r      <= fl2_r;
      col_hit3_r <= col_hit2_r;
    end
  end

  // ---------------- stage 4: classification into the output register
  logic  nu_in, nv_in;
  logic  hit_nxt;
  kind_t kind_nxt;
  logic  hit_r;
  kind_t kind_r;

  // num/den in [0,1] without dividing; den is nonzero where this is used
  always_comb begin
    if (den_r > 0) begin
      nu_in = (nu_r >= 0) && (nu_r <= den_r);
      nv_in = (nv_r >= 0) && (nv_r <= den_r);
    end else begin
      nu_in = (nu_r <= 0) && (nu_r >= den_r);
      nv_in = (nv_r <= 0) && (nv_r >= den_r);
    end
  end

  always_comb begin
    priority if (den_r != '0) begin
      kind_nxt = KIND_NONPARALLEL;
      hit_nxt  = nu_in && nv_in;
    end else if ((nu_r != '0) || (nv_r != '0)) begin
      kind_nxt = KIND_PARALLEL;
      hit_nxt  = 1'b0;
    end else if (fl3_r.u_point && fl3_r.v_point) begin
      kind_nxt = KIND_POINT;
      hit_nxt  = fl3_r.pts_equal;
    end else if (fl3_r.u_point) begin
      kind_nxt = KIND_POINT;
      hit_nxt  = fl3_r.a_in_b;
    end else if (fl3_r.v_point) begin
      kind_nxt = KIND_POINT;
      hit_nxt  = fl3_r.b_in_a;
    end else begin
      kind_nxt = KIND_COLLINEAR;
      hit_nxt  = col_hit3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      hit_r  <= hit_nxt;
      kind_r <= kind_nxt;
    end
  end

  assign out_valid     = v4_r;
  assign out_touches   = hit_r;
  assign out_case_kind = kind_r;

endmodule

// File: sim/tb_segment_pair_intersection_test.sv
// Self-checking testbench for the pipelined segment pair intersection test.
module tb_segment_pair_intersection_test import spit_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = 16;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct packed {
    logic  touches;
    kind_t kind;
  } contact_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      out_touches;
  logic [1:0] out_case_kind;
  seg_pair_t drive_pair = '0;

  seg_pair_t pending_pairs[$];
  contact_t  contacts_due[$];
  contact_t  got_contact;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_request = 1'b0;
  int        hold_left = 0;
  int        cycle_count = 0;
  int        mismatch_count = 0;

  segment_pair_intersection_test #(.COORD_BITS(CW)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_start_x (drive_pair.ax0),
    .in_a_start_y (drive_pair.ay0),
    .in_a_end_x   (drive_pair.ax1),
    .in_a_end_y   (drive_pair.ay1),
    .in_b_start_x (drive_pair.bx0),
    .in_b_start_y (drive_pair.by0),
    .in_b_end_x   (drive_pair.bx1),
    .in_b_end_y   (drive_pair.by1),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_touches  (out_touches),
    .out_case_kind(out_case_kind)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [2*CW+2:0] cross_product(
    logic signed [CW:0] ax, logic signed [CW:0] ay,
    logic signed [CW:0] bx, logic signed [CW:0] by);
    logic signed [2*CW+2:0] r;
    r = ax * by - ay * bx;
    return r;
  endfunction

  // num/den within [0,1], den nonzero
  function automatic logic in_unit(logic signed [2*CW+2:0] num,
                                   logic signed [2*CW+2:0] den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return num >= 0 && num <= den;
  endfunction

  // span is taken on x, or on y when the segment is vertical
  function automatic logic point_in_span(
    logic signed [CW-1:0] px, logic signed [CW-1:0] py,
    logic signed [CW-1:0] s0x, logic signed [CW-1:0] s0y,
    logic signed [CW-1:0] s1x, logic signed [CW-1:0] s1y);
    logic signed [CW-1:0] lo, hi, pt, t;
    if (s0x != s1x) begin
      lo = s0x; hi = s1x; pt = px;
    end else begin
      lo = s0y; hi = s1y; pt = py;
    end
    if (lo > hi) begin
      t = lo; lo = hi; hi = t;
    end
    return lo <= pt && pt <= hi;
  endfunction

  function automatic contact_t predict_contact(seg_pair_t p);
    logic signed [CW:0]     ux, uy, vx, vy, wx, wy;
    logic signed [2*CW+2:0] den, nu, nv;
    logic signed [CW+1:0]   n0, n1, d, lo, hi;
    logic                   upt, vpt;
    contact_t               r;
    ux = p.ax1 - p.ax0;
    uy = p.ay1 - p.ay0;
    vx = p.bx1 - p.bx0;
    vy = p.by1 - p.by0;
    wx = p.ax0 - p.bx0;
    wy = p.ay0 - p.by0;
    den = cross_product(ux, uy, vx, vy);
    nu  = cross_product(ux, uy, wx, wy);
    nv  = cross_product(vx, vy, wx, wy);
    upt = (ux == 0) && (uy == 0);
    vpt = (vx == 0) && (vy == 0);
    if (den != 0) begin
      r.kind    = KIND_NONPARALLEL;
      r.touches = in_unit(nv, den) && in_unit(nu, den);
    end else if (nu != 0 || nv != 0) begin
      r.kind    = KIND_PARALLEL;
      r.touches = 1'b0;
    end else if (upt && vpt) begin
      r.kind    = KIND_POINT;
      r.touches = (p.ax0 == p.bx0) && (p.ay0 == p.by0);
    end else if (upt) begin
      r.kind    = KIND_POINT;
      r.touches = point_in_span(p.ax0, p.ay0, p.bx0, p.by0, p.bx1, p.by1);
    end else if (vpt) begin
      r.kind    = KIND_POINT;
      r.touches = point_in_span(p.bx0, p.by0, p.ax0, p.ay0, p.ax1, p.ay1);
    end else begin
      // collinear: project both ends of A onto B's x axis, or y when B is vertical
      r.kind = KIND_COLLINEAR;
      if (vx != 0) begin
        n0 = wx; n1 = p.ax1 - p.bx0; d = vx;
      end else begin
        n0 = wy; n1 = p.ay1 - p.by0; d = vy;
      end
      if (d < 0) begin
        n0 = -n0; n1 = -n1; d = -d;
      end
      lo = (n0 < n1) ? n0 : n1;
      hi = (n0 < n1) ? n1 : n0;
      r.touches = !(lo > d || hi < 0);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int span_rand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic seg_pair_t pack_pair(int c0, int c1, int c2, int c3,
                                          int c4, int c5, int c6, int c7);
    seg_pair_t p;
    p.ax0 = c0[CW-1:0]; p.ay0 = c1[CW-1:0];
    p.ax1 = c2[CW-1:0]; p.ay1 = c3[CW-1:0];
    p.bx0 = c4[CW-1:0]; p.by0 = c5[CW-1:0];
    p.bx1 = c6[CW-1:0]; p.by1 = c7[CW-1:0];
    return p;
  endfunction

  function automatic seg_pair_t random_pair();
    int pick, i, cx, cy, dx, dy, ex, ey, t0, t1, t2, t3, tr, ox, oy;
    int co[8];
    pick = $urandom_range(99);
    ox = 0;
    oy = 0;
    if (pick < 25) begin
      for (i = 0; i < 8; i++) co[i] = span_rand(-32768, 32767);
    end else if (pick < 45) begin
      // tight box: parallels, collinear runs and points turn up on their own
      for (i = 0; i < 8; i++) co[i] = span_rand(-8, 8);
    end else if (pick < 75) begin
      // four points on one line; B moved off it for the parallel share
      cx = span_rand(-8000, 8000);
      cy = span_rand(-8000, 8000);
      if ($urandom_range(1)) begin
        dx = span_rand(-64, 64); dy = span_rand(-64, 64); tr = 200;
      end else begin
        dx = span_rand(-8000, 8000); dy = span_rand(-8000, 8000); tr = 3;
      end
      case ($urandom_range(3))
        0: dx = 0;
        1: dy = 0;
        default: ;
      endcase
      t0 = span_rand(-tr, tr);
      t1 = span_rand(-tr, tr);
      t2 = span_rand(-tr, tr);
      t3 = span_rand(-tr, tr);
      if ($urandom_range(5) == 0) t1 = t0;
      if ($urandom_range(5) == 0) t3 = t2;
      if (pick >= 65) begin
        ox = span_rand(-3, 3);
        oy = span_rand(-3, 3);
      end
      co = '{cx + t0*dx, cy + t0*dy, cx + t1*dx, cy + t1*dy,
             cx + t2*dx + ox, cy + t2*dy + oy, cx + t3*dx + ox, cy + t3*dy + oy};
    end else if (pick < 90) begin
      // two segments through a common point, often ending on it
      cx = span_rand(-8000, 8000);
      cy = span_rand(-8000, 8000);
      dx = span_rand(-2000, 2000);
      dy = span_rand(-2000, 2000);
      ex = span_rand(-2000, 2000);
      ey = span_rand(-2000, 2000);
      t0 = span_rand(0, 3);
      t1 = span_rand(0, 3);
      t2 = span_rand(0, 3);
      t3 = span_rand(0, 3);
      if ($urandom_range(2) == 0) ox = span_rand(-1, 1);
      co = '{cx - t0*dx, cy - t0*dy, cx + t1*dx, cy + t1*dy,
             cx - t2*ex + ox, cy - t2*ey, cx + t3*ex + ox, cy + t3*ey};
    end else begin
      for (i = 0; i < 8; i++) begin
        case ($urandom_range(5))
          0: co[i] = -32768;
          1: co[i] = 32767;
          2: co[i] = 0;
          3: co[i] = -1;
          4: co[i] = 1;
          default: co[i] = span_rand(-32768, 32767);
        endcase
      end
    end
    return pack_pair(co[0], co[1], co[2], co[3], co[4], co[5], co[6], co[7]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || contacts_due.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) contacts_due.push_back(predict_contact(drive_pair));
      if (!in_valid || in_ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_pair <= pending_pairs.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (contacts_due.size() == 0) begin
          report_mismatch($sformatf("result touches=%0b kind=%0d with no item pending",
                                    out_touches, out_case_kind));
        end else begin
          got_contact = contacts_due.pop_front();
          if (out_touches !== got_contact.touches)
            report_mismatch($sformatf("touches %0b, want %0b",
                                      out_touches, got_contact.touches));
          if (out_case_kind !== got_contact.kind)
            report_mismatch($sformatf("case_kind %0d, want %s",
                                      out_case_kind, got_contact.kind.name()));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    send_idle_pct = 15;
    recv_idle_pct = 79;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // points: equal, distinct, equal at the corner
    pending_pairs.push_back(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(1, 2, 1, 2, 3, 4, 3, 4));
    pending_pairs.push_back(pack_pair(-32768, 32767, -32768, 32767,
                                      -32768, 32767, -32768, 32767));
    // full-range diagonals crossing, then parallel full-range lines
    pending_pairs.push_back(pack_pair(-32768, -32768, 32767, 32767,
                                      -32768, 32767, 32767, -32768));
    pending_pairs.push_back(pack_pair(-32768, -32768, 32767, 32767,
                                      -32768, -32767, 32766, 32767));
    pending_pairs.push_back(pack_pair(-32768, 0, 32767, 0, 32767, 1, -32768, 1));
    // collinear, opposite directions over the full range
    pending_pairs.push_back(pack_pair(32767, 32767, -32768, -32768,
                                      -32768, -32768, 32767, 32767));
    // collinear horizontal: overlap, end contact, gap, A inside a reversed B
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 5, 0, 20, 0));
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 10, 0, 20, 0));
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 11, 0, 20, 0));
    pending_pairs.push_back(pack_pair(10, 0, 0, 0, 20, 0, -5, 0));
    // collinear vertical: end contact, gap
    pending_pairs.push_back(pack_pair(3, -5, 3, 5, 3, 5, 3, 9));
    pending_pairs.push_back(pack_pair(3, -5, 3, 5, 3, 6, 3, 9));
    // A a point: on B, off B's line, on the line beyond B
    pending_pairs.push_back(pack_pair(5, 5, 5, 5, 0, 0, 10, 10));
    pending_pairs.push_back(pack_pair(5, 6, 5, 6, 0, 0, 10, 10));
    pending_pairs.push_back(pack_pair(11, 11, 11, 11, 0, 0, 10, 10));
    // B a point against vertical A: inside, beyond
    pending_pairs.push_back(pack_pair(3, -5, 3, 5, 3, 2, 3, 2));
    pending_pairs.push_back(pack_pair(3, -5, 3, 5, 3, 7, 3, 7));
    // nonparallel: T contact, near miss, end of A, beyond A, negative den
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 5, 0, 5, 10));
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 5, 1, 5, 10));
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 10, -5, 10, 5));
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 11, -5, 11, 5));
    pending_pairs.push_back(pack_pair(0, 0, 10, 0, 5, 5, 5, -5));
    repeat (400) pending_pairs.push_back(random_pair());
    wait_drained();

    // receiver stalls long while the sender keeps pushing
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    @(negedge clk);
    hold_request = 1'b0;
    repeat (100) pending_pairs.push_back(random_pair());
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 15;
    repeat (380) pending_pairs.push_back(random_pair());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (350) pending_pairs.push_back(random_pair());
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/spit_pkg.sv
src/spit_prep.sv
src/segment_pair_intersection_test.sv
sim/tb_segment_pair_intersection_test.sv
